// ----- src/pid_integral_separation_clamp_defines.svh -----
// assertion macros for the pid controller checker
// needs clk and arst_n in the scope of each use
`ifndef PID_INTEGRAL_SEPARATION_CLAMP_DEFINES_SVH
`define PID_INTEGRAL_SEPARATION_CLAMP_DEFINES_SVH

// same-cycle implication
`define PISC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PISC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pisc_pkg.sv -----
// shared widths, register indexes and the multiplier request type
// no dependencies
`timescale 1ns / 1ps

package pisc_pkg;

	localparam int GAIN_W    = 24;
	localparam int CALG_W    = 18;
	localparam int CALO_W    = 16;
	localparam int LIM_W     = 15;
	localparam int SP_W      = 13;
	localparam int RAW_W     = 12;
	localparam int DRIVE_W   = 48;
	localparam int ERR_W     = 16;
	localparam int SUM_W     = 32;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 24;
	localparam int MUL_A_W   = 25;
	localparam int MUL_B_W   = 33;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int ACC_W     = 60;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 4'd0,
		REG_INTEG_GAIN = 4'd1,
		REG_DERIV_GAIN = 4'd2,
		REG_CAL_GAIN   = 4'd3,
		REG_CAL_OFFSET = 4'd4,
		REG_UPPER_LIM  = 4'd5,
		REG_LOWER_LIM  = 4'd6,
		REG_SEP_BAND   = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic               en;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

// ----- src/pisc_mul.sv -----
// shared signed multiplier with registered product
// depends on pisc_pkg
`timescale 1ns / 1ps

module pisc_mul (
	input  logic                              clk,
	input  pisc_pkg::mul_req_t                req,
	output logic signed [pisc_pkg::PROD_W-1:0] prod
);
	import pisc_pkg::*;

	logic signed [MUL_A_W-1:0] a_s;
	logic signed [MUL_B_W-1:0] b_s;

	assign a_s = $signed(req.a);
	assign b_s = $signed(req.b);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod <= a_s * b_s;
		end
	end

endmodule

// ----- src/pid_integral_separation_clamp.sv -----
// pid controller with integral separation and limit anti-windup, top level
// depends on pisc_pkg and pisc_mul
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------
//   config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//   sample   | sample_valid / sample_stall | setpoint, raw_sample
//   result   | result_valid / result_stall | drive, error_value, integral_on
//
// one request at a time, stalled until idle: the calibration product and the three gain
// products go through the single 25x33 multiplier in turn, then the sum is saturated
// a new request is taken while the previous result still waits downstream
// reset loads the register defaults and clears the integral and last error
// a stalled result holds; the sequencer waits in its last step until free
`timescale 1ns / 1ps

module pid_integral_separation_clamp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pisc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pisc_pkg::CFG_DAT_W-1:0]         cfg_data,
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  logic [pisc_pkg::SP_W-1:0]              setpoint,
	input  logic [pisc_pkg::RAW_W-1:0]             raw_sample,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [pisc_pkg::DRIVE_W-1:0]    drive,
	output logic signed [pisc_pkg::ERR_W-1:0]      error_value,
	output logic                                   integral_on
);
	import pisc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAL,
		ST_MEAS,
		ST_EVAL,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I,
		ST_SUM,
		ST_DONE
	} state_t;

	state_t state_q;

	logic signed [GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [CALG_W-1:0]        cal_gain_q;
	logic [CALO_W-1:0]        cal_offset_q;
	logic signed [LIM_W-1:0]  upper_lim_q, lower_lim_q;
	logic [LIM_W-1:0]         sep_band_q;

	logic [SP_W-1:0]          sp_q;
	logic [RAW_W-1:0]         raw_q;
	logic signed [ERR_W-1:0]  meas_q, err_q, prev_q;
	logic signed [ERR_W:0]    diff_q;
	logic signed [SUM_W-1:0]  isum_q;
	logic                     on_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [DRIVE_W-1:0] drive_q;
	logic signed [ERR_W-1:0]   error_value_q;
	logic                      integral_on_q;
	logic                      result_valid_q;

	mul_req_t                  mul_req;
	logic signed [PROD_W-1:0]  prod;

	logic signed [31:0]        q16_d, q16_adj_d;
	logic signed [ERR_W-1:0]   meas_d, err_d;
	logic [ERR_W-1:0]          mag_d;
	logic                      on_d;
	logic signed [ERR_W:0]     diff_d;
	logic signed [ERR_W-1:0]   upper_ext, lower_ext;
	logic                      add_d;
	logic signed [SUM_W:0]     sum_wide_d;
	logic signed [SUM_W-1:0]   sum_sat_d;
	logic signed [ACC_W-1:0]   prod_ext;
	logic                      acc_fits;
	logic signed [DRIVE_W-1:0] drive_sat_d;
	logic                      out_free;

	pisc_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	assign cfg_ready    = 1'b1;
	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign drive        = drive_q;
	assign error_value  = error_value_q;
	assign integral_on  = integral_on_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_req = '0;
		case (state_q)
			ST_CAL: begin
				mul_req.en = 1'b1;
				mul_req.a  = {{(MUL_A_W-CALG_W){1'b0}}, cal_gain_q};
				mul_req.b  = {{(MUL_B_W-RAW_W){1'b0}}, raw_q};
			end
			ST_MUL_P: begin
				mul_req.en = 1'b1;
				mul_req.a  = {prop_gain_q[GAIN_W-1], prop_gain_q};
				mul_req.b  = {{(MUL_B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
			end
			ST_MUL_D: begin
				mul_req.en = 1'b1;
				mul_req.a  = {deriv_gain_q[GAIN_W-1], deriv_gain_q};
				mul_req.b  = {{(MUL_B_W-ERR_W-1){diff_q[ERR_W]}}, diff_q};
			end
			ST_MUL_I: begin
				mul_req.en = 1'b1;
				mul_req.a  = on_q ? {integ_gain_q[GAIN_W-1], integ_gain_q} : '0;
				mul_req.b  = {isum_q[SUM_W-1], isum_q};
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	// calibration: truncate toward zero
	always_comb begin
		q16_d     = $signed({2'b00, prod[29:0]}) - $signed({8'h00, cal_offset_q, 8'h00});
		q16_adj_d = q16_d + (q16_d[31] ? 32'sh0000_FFFF : 32'sh0000_0000);
		meas_d    = q16_adj_d[31:16];
	end

	// error, separation test, derivative difference
	always_comb begin
		err_d  = $signed({3'b000, sp_q}) - meas_q;
		mag_d  = err_d[ERR_W-1] ? 16'(-err_d) : 16'(err_d);
		on_d   = (mag_d <= {1'b0, sep_band_q});
		diff_d = {err_d[ERR_W-1], err_d} - {prev_q[ERR_W-1], prev_q};
	end

	// one-sided integration outside the limits, saturating sum
	always_comb begin
		upper_ext = {upper_lim_q[LIM_W-1], upper_lim_q};
		lower_ext = {lower_lim_q[LIM_W-1], lower_lim_q};
		if (meas_q > upper_ext) begin
			add_d = err_q[ERR_W-1];
		end else if (meas_q < lower_ext) begin
			add_d = !err_q[ERR_W-1] && (err_q != '0);
		end else begin
			add_d = 1'b1;
		end
		sum_wide_d = {isum_q[SUM_W-1], isum_q} + {{(SUM_W-ERR_W+1){err_q[ERR_W-1]}}, err_q};
		if (sum_wide_d[SUM_W] != sum_wide_d[SUM_W-1]) begin
			sum_sat_d = sum_wide_d[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat_d = sum_wide_d[SUM_W-1:0];
		end
	end

	// accumulation and output saturation
	always_comb begin
		prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
		acc_fits = (&acc_q[ACC_W-1:DRIVE_W-1]) || !(|acc_q[ACC_W-1:DRIVE_W-1]);
		if (acc_fits) begin
			drive_sat_d = acc_q[DRIVE_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			drive_sat_d = {1'b1, {(DRIVE_W-1){1'b0}}};
		end else begin
			drive_sat_d = {1'b0, {(DRIVE_W-1){1'b1}}};
		end
		out_free = !result_valid_q || !result_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			prop_gain_q    <= 24'sd6554;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			cal_gain_q     <= 18'd89384;
			cal_offset_q   <= 16'd39306;
			upper_lim_q    <= 15'sd3500;
			lower_lim_q    <= '0;
			sep_band_q     <= 15'd3500;
			sp_q           <= '0;
			raw_q          <= '0;
			meas_q         <= '0;
			err_q          <= '0;
			prev_q         <= '0;
			diff_q         <= '0;
			isum_q         <= '0;
			on_q           <= 1'b0;
			acc_q          <= '0;
			drive_q        <= '0;
			error_value_q  <= '0;
			integral_on_q  <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
					REG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
					REG_DERIV_GAIN: deriv_gain_q <= cfg_data[GAIN_W-1:0];
					REG_CAL_GAIN:   cal_gain_q   <= cfg_data[CALG_W-1:0];
					REG_CAL_OFFSET: cal_offset_q <= cfg_data[CALO_W-1:0];
					REG_UPPER_LIM:  upper_lim_q  <= cfg_data[LIM_W-1:0];
					REG_LOWER_LIM:  lower_lim_q  <= cfg_data[LIM_W-1:0];
					REG_SEP_BAND:   sep_band_q   <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end

			if (result_valid_q && !result_stall && (state_q != ST_DONE)) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						sp_q    <= setpoint;
						raw_q   <= raw_sample;
						state_q <= ST_CAL;
					end
				end
				ST_CAL: begin
					state_q <= ST_MEAS;
				end
				ST_MEAS: begin
					meas_q  <= meas_d;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					err_q   <= err_d;
					on_q    <= on_d;
					diff_q  <= diff_d;
					prev_q  <= err_d;
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: begin
					if (on_q && add_d) begin
						isum_q <= sum_sat_d;
					end
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: begin
					acc_q   <= prod_ext;
					state_q <= ST_MUL_I;
				end
				ST_MUL_I: begin
					acc_q   <= acc_q + prod_ext;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					acc_q   <= acc_q + prod_ext;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						drive_q        <= drive_sat_d;
						error_value_q  <= err_q;
						integral_on_q  <= on_q;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/pisc_chk.sv -----
// port-level checker for the pid controller, bound to the top level
// depends on pid_integral_separation_clamp_defines.svh
`timescale 1ns / 1ps
`include "pid_integral_separation_clamp_defines.svh"

module pisc_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [15:0] error_value,
	input logic               integral_on
);

	// a held result stays offered
	`PISC_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid, "result dropped while stalled")

	// a taken request keeps the block busy
	`PISC_ASSERT_NXT(a_busy_after_req, sample_valid && !sample_stall, sample_stall, "request taken while not busy")

	// a result only appears at the end of a busy spell
	`PISC_ASSERT_IMP(a_result_from_work, $rose(result_valid), $past(sample_stall), "result without work")

	// separation implies a nonzero error
	`PISC_ASSERT_IMP(a_sep_nonzero, result_valid && !integral_on, error_value != 16'sd0, "separated on zero error")

endmodule

bind pid_integral_separation_clamp pisc_chk u_chk (.*);

// ----- dv/tb_pid_integral_separation_clamp.sv -----
// self-checking bench for pid_integral_separation_clamp: drives samples and config writes,
// predicts each result in-bench and compares it field by field with what the block returns
// depends on pisc_pkg and the pid_integral_separation_clamp rtl
`timescale 1ns / 1ps

module tb_pid_integral_separation_clamp;
	import pisc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1500000;
	localparam int unsigned RAND_PHASES = 7;
	localparam int unsigned PHASE_ITEMS = 90;
	localparam int unsigned WINDUP_ITEMS = 1100;
	localparam longint DRIVE_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint DRIVE_LO = -DRIVE_HI - 1;
	localparam longint SUM_HI = 64'sd2147483647;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam logic [CFG_DAT_W-1:0] GAIN_MAX = 24'h7FFFFF;
	localparam logic [CFG_DAT_W-1:0] GAIN_MIN = 24'h800000;

	typedef struct {
		logic [SP_W-1:0]  sp;
		logic [RAW_W-1:0] raw;
	} sample_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [ERR_W-1:0]   err;
		logic                      on;
	} ctrl_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DAT_W-1:0]  cfg_data = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	logic [SP_W-1:0]       setpoint = '0;
	logic [RAW_W-1:0]      raw_sample = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic signed [DRIVE_W-1:0] drive;
	logic signed [ERR_W-1:0]   error_value;
	logic                  integral_on;

	// register copies
	logic signed [GAIN_W-1:0] kp_r = 24'sd6554;
	logic signed [GAIN_W-1:0] ki_r = '0;
	logic signed [GAIN_W-1:0] kd_r = '0;
	logic [CALG_W-1:0]        calg_r = 18'd89384;
	logic [CALO_W-1:0]        calo_r = 16'd39306;
	logic signed [LIM_W-1:0]  upper_r = 15'sd3500;
	logic signed [LIM_W-1:0]  lower_r = '0;
	logic [LIM_W-1:0]         band_r = 15'd3500;

	longint integ_sum = 0;
	longint last_err = 0;

	sample_t     sample_q[$];
	ctrl_t       pending_ctrl[$];
	logic        pace_calm = 1'b1;
	int unsigned fails = 0;
	int unsigned cycles = 0;
	int unsigned idle_left = 0;
	int unsigned stall_left = 0;

	pid_integral_separation_clamp uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.setpoint    (setpoint),
		.raw_sample  (raw_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.drive       (drive),
		.error_value (error_value),
		.integral_on (integral_on)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic ctrl_t predict_ctrl(input logic [SP_W-1:0] sp, input logic [RAW_W-1:0] raw);
		longint meas;
		longint e;
		longint mag;
		longint d;
		logic   on;
		logic   add;
		ctrl_t  r;
		meas = (longint'(raw) * longint'(calg_r) - (longint'(calo_r) << 8)) / 64'sd65536;
		e = longint'(sp) - meas;
		mag = (e < 0) ? -e : e;
		on = (mag <= longint'(band_r));
		if (on) begin
			if (meas > longint'(upper_r))
				add = (e < 0);
			else if (meas < longint'(lower_r))
				add = (e > 0);
			else
				add = 1'b1;
			if (add) begin
				integ_sum = integ_sum + e;
				if (integ_sum > SUM_HI) integ_sum = SUM_HI;
				if (integ_sum < SUM_LO) integ_sum = SUM_LO;
			end
		end
		d = longint'(kp_r) * e + longint'(kd_r) * (e - last_err);
		if (on)
			d = d + longint'(ki_r) * integ_sum;
		if (d > DRIVE_HI) d = DRIVE_HI;
		if (d < DRIVE_LO) d = DRIVE_LO;
		last_err = e;
		r.drive = d[DRIVE_W-1:0];
		r.err = e[ERR_W-1:0];
		r.on = on;
		return r;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		case (idx)
			REG_PROP_GAIN:  kp_r = val[GAIN_W-1:0];
			REG_INTEG_GAIN: ki_r = val[GAIN_W-1:0];
			REG_DERIV_GAIN: kd_r = val[GAIN_W-1:0];
			REG_CAL_GAIN:   calg_r = val[CALG_W-1:0];
			REG_CAL_OFFSET: calo_r = val[CALO_W-1:0];
			REG_UPPER_LIM:  upper_r = val[LIM_W-1:0];
			REG_LOWER_LIM:  lower_r = val[LIM_W-1:0];
			REG_SEP_BAND:   band_r = val[LIM_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic int unsigned draw_gap();
		int unsigned r;
		if (pace_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [CFG_DAT_W-1:0] rand_gain();
		if ($urandom_range(0, 1) == 0)
			return CFG_DAT_W'($urandom());
		return CFG_DAT_W'(int'($urandom_range(0, 262144)) - 131072);
	endfunction

	function automatic logic [CFG_DAT_W-1:0] rand_limit();
		if ($urandom_range(0, 1) == 0)
			return CFG_DAT_W'($urandom());
		return CFG_DAT_W'(int'($urandom_range(0, 6256)) - 256);
	endfunction

	function automatic void queue_sample(input logic [SP_W-1:0] sp, input logic [RAW_W-1:0] raw);
		sample_t s;
		s.sp = sp;
		s.raw = raw;
		sample_q.push_back(s);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		apply_reg(idx, val);
	endtask

	task automatic drain();
		@(negedge clk);
		while (sample_q.size() != 0 || sample_valid || pending_ctrl.size() != 0)
			@(negedge clk);
	endtask

	// sample driver
	always @(posedge clk) begin : drv
		sample_t nxt;
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				pending_ctrl.push_back(predict_ctrl(setpoint, raw_sample));
			if (!sample_valid || !sample_stall) begin
				if (idle_left > 0) begin
					idle_left = idle_left - 1;
					sample_valid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					nxt = sample_q.pop_front();
					sample_valid <= 1'b1;
					setpoint <= nxt.sp;
					raw_sample <= nxt.raw;
					idle_left = draw_gap();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : mon
		ctrl_t want;
		int unsigned n;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_ctrl.size() == 0) begin
					fails = fails + 1;
					if (fails <= 10)
						$display("unexpected result: drive %0d err %0d integ %0b",
							drive, error_value, integral_on);
				end else begin
					want = pending_ctrl.pop_front();
					if (drive !== want.drive || error_value !== want.err
						|| integral_on !== want.on) begin
						fails = fails + 1;
						if (fails <= 10)
							$display("mismatch: drive %0d/%0d err %0d/%0d integ %0b/%0b",
								want.drive, drive, want.err, error_value,
								want.on, integral_on);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				result_stall <= 1'b1;
			end else begin
				n = draw_gap();
				result_stall <= (n != 0);
				if (n != 0)
					stall_left = n - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset calibration and limits, gains made active
		pace_calm = 1'b1;
		write_reg(REG_PROP_GAIN, 24'd65536);
		write_reg(REG_INTEG_GAIN, 24'd1000);
		write_reg(REG_DERIV_GAIN, CFG_DAT_W'(-30000));
		queue_sample(13'd0, 12'd0);
		queue_sample(13'd0, 12'd50);
		queue_sample(13'd3000, 12'd3000);
		queue_sample(13'd4500, 12'd3000);
		queue_sample(13'h1FFF, 12'h000);
		queue_sample(13'h1FFF, 12'hFFF);
		queue_sample(13'd0, 12'hFFF);
		queue_sample(13'd2000, 12'd1500);
		drain();

		// raised lower limit, widest band, extreme p and d gains
		pace_calm = 1'b0;
		write_reg(REG_LOWER_LIM, 24'd1000);
		write_reg(REG_UPPER_LIM, 24'd16383);
		write_reg(REG_SEP_BAND, 24'd32767);
		write_reg(REG_DERIV_GAIN, GAIN_MAX);
		write_reg(REG_PROP_GAIN, GAIN_MIN);
		queue_sample(13'd0, 12'd500);
		queue_sample(13'd2000, 12'd500);
		queue_sample(13'h1FFF, 12'h000);
		drain();

		// full-scale calibration, both limits at -256, zero band, most negative integral gain
		write_reg(REG_CAL_GAIN, 24'd262143);
		write_reg(REG_CAL_OFFSET, 24'd0);
		write_reg(REG_UPPER_LIM, CFG_DAT_W'(-256));
		write_reg(REG_LOWER_LIM, CFG_DAT_W'(-256));
		write_reg(REG_SEP_BAND, 24'd0);
		write_reg(REG_INTEG_GAIN, GAIN_MIN);
		queue_sample(13'd0, 12'hFFF);
		queue_sample(13'h1FFF, 12'hFFF);
		queue_sample(13'd0, 12'd0);
		queue_sample(13'd5, 12'd0);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			pace_calm = (ph % 3 == 2);
			write_reg(REG_PROP_GAIN, ph == 1 ? GAIN_MAX : ph == 2 ? GAIN_MIN : rand_gain());
			write_reg(REG_INTEG_GAIN, ph == 1 ? GAIN_MAX : ph == 2 ? GAIN_MIN : rand_gain());
			write_reg(REG_DERIV_GAIN, ph == 1 ? GAIN_MAX : ph == 2 ? GAIN_MIN : rand_gain());
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_CAL_GAIN, CFG_DAT_W'($urandom_range(60000, 120000)));
			else
				write_reg(REG_CAL_GAIN, CFG_DAT_W'($urandom()));
			write_reg(REG_CAL_OFFSET, CFG_DAT_W'($urandom()));
			write_reg(REG_UPPER_LIM, rand_limit());
			write_reg(REG_LOWER_LIM, rand_limit());
			if ($urandom_range(0, 4) < 3)
				write_reg(REG_SEP_BAND, CFG_DAT_W'($urandom_range(0, 6000)));
			else
				write_reg(REG_SEP_BAND, CFG_DAT_W'($urandom()));
			// unmapped index must leave every register alone
			write_reg(CFG_IDX_W'($urandom_range(8, 15)), CFG_DAT_W'($urandom()));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					queue_sample(13'h1FFF, 12'h000);
				else if (r == 1)
					queue_sample(13'd0, 12'hFFF);
				else
					queue_sample(SP_W'($urandom_range(0, 8191)), RAW_W'($urandom_range(0, 4095)));
			end
		end

		// wind the integral down until the drive saturates low, then flip ki for high
		drain();
		pace_calm = 1'b1;
		write_reg(REG_PROP_GAIN, GAIN_MAX);
		write_reg(REG_INTEG_GAIN, GAIN_MAX);
		write_reg(REG_DERIV_GAIN, 24'd0);
		write_reg(REG_CAL_GAIN, 24'd262143);
		write_reg(REG_CAL_OFFSET, 24'd0);
		write_reg(REG_UPPER_LIM, 24'd16383);
		write_reg(REG_LOWER_LIM, CFG_DAT_W'(-256));
		write_reg(REG_SEP_BAND, 24'd32767);
		for (int k = 0; k < WINDUP_ITEMS; k++)
			queue_sample(13'd0, 12'hFFF);
		drain();
		pace_calm = 1'b0;
		write_reg(REG_INTEG_GAIN, GAIN_MIN);
		queue_sample(13'h1FFF, 12'd0);
		queue_sample(13'h1FFF, 12'hFFF);
		queue_sample(13'd0, 12'd0);

		drain();
		repeat (20) @(posedge clk);
		fails = fails + pending_ctrl.size();
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
